// ===== src/irpx_pkg.sv =====
// Shared types and constants for the IR proximity ambient-cancel averager.
// No dependencies.
package irpx_pkg;

  localparam int NUM_CH   = 3;
  localparam int OUT_BITS = 12;
  localparam int IN_BITS  = 12;

  typedef enum logic [1:0] {
    PH_START_AMB = 2'd0,
    PH_WAIT_AMB  = 2'd1,
    PH_START_LIT = 2'd2,
    PH_WAIT_LIT  = 2'd3
  } phase_t;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_CONV = 1'b1
  } req_t;

endpackage

// ===== src/ir_proximity_ambient_cancel_average.sv =====
// Top level: phase sequencer, ambient store, result register, window chain.
// Depends on irpx_pkg, irpx_chain, irpx_cell.
//
//   channel  handshake           payload
//   in       in_valid/in_ready   req_type, sample_front_right/left, sample_back
//   out      out_valid/out_ready start_conversion, emitter_on, phase_now, avg_*
//
// A new beat is taken every cycle while the result
// register is empty or being drained. The window sums update in the accepting
// cycle, so the result appears the cycle after. Synchronous reset clears the
// phase, emitter, ambient samples, window cells and sums. A stalled output
// holds in_ready low.
module ir_proximity_ambient_cancel_average #(
  parameter int WINDOW      = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [irpx_pkg::IN_BITS-1:0]  sample_front_right,
  input  logic [irpx_pkg::IN_BITS-1:0]  sample_front_left,
  input  logic [irpx_pkg::IN_BITS-1:0]  sample_back,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          start_conversion,
  output logic                          emitter_on,
  output logic [1:0]                    phase_now,
  output logic [irpx_pkg::OUT_BITS-1:0] avg_front_right,
  output logic [irpx_pkg::OUT_BITS-1:0] avg_front_left,
  output logic [irpx_pkg::OUT_BITS-1:0] avg_back
);
  import irpx_pkg::*;

  localparam int SB = (SAMPLE_BITS < IN_BITS) ? SAMPLE_BITS : IN_BITS;

  phase_t        phase, phase_next;
  logic          emitter, emitter_next;
  logic          start, start_next;
  logic          accept;
  logic          conv;
  logic          lit_en;
  logic [SB-1:0] smp     [NUM_CH];
  logic [SB-1:0] ambient [NUM_CH];
  logic [SB-1:0] avg     [NUM_CH];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign conv     = (req_t'(req_type) == REQ_CONV);

  assign smp[0] = sample_front_right[SB-1:0];
  assign smp[1] = sample_front_left[SB-1:0];
  assign smp[2] = sample_back[SB-1:0];

  always_comb begin
    unique case (phase)
      PH_START_AMB: phase_next = PH_WAIT_AMB;
      PH_WAIT_AMB:  phase_next = PH_START_LIT;
      PH_START_LIT: phase_next = PH_WAIT_LIT;
      PH_WAIT_LIT:  phase_next = PH_START_AMB;
      default:      phase_next = PH_START_AMB;
    endcase
  end

  always_comb begin
    start_next   = 1'b0;
    emitter_next = emitter;
    unique case (phase)
      PH_START_AMB: start_next   = 1'b1;
      PH_WAIT_AMB:  emitter_next = 1'b1;
      PH_START_LIT: start_next   = 1'b1;
      PH_WAIT_LIT:  emitter_next = 1'b0;
      default:      emitter_next = emitter;
    endcase
  end

  assign lit_en = accept && conv && (phase == PH_WAIT_LIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START_AMB;
      emitter   <= 1'b0;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase   <= phase_next;
        emitter <= emitter_next;
        start   <= start_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) ambient[c] <= '0;
    end else if (accept && conv && (phase == PH_WAIT_AMB)) begin
      ambient <= smp;
    end
  end

  irpx_chain #(.WINDOW(WINDOW), .SB(SB)) u_chain (
    .clk     (clk),
    .rst     (rst),
    .lit_en  (lit_en),
    .lit     (smp),
    .ambient (ambient),
    .avg     (avg)
  );

  assign start_conversion = start;
  assign emitter_on       = emitter;
  assign phase_now        = phase;
  assign avg_front_right  = OUT_BITS'(avg[0]);
  assign avg_front_left   = OUT_BITS'(avg[1]);
  assign avg_back         = OUT_BITS'(avg[2]);

endmodule

// ===== src/irpx_cell.sv =====
// One window slot: holds the clamped difference of every channel.
// Depends on irpx_pkg.
module irpx_cell #(
  parameter int SB = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  logic [SB-1:0] d_in  [irpx_pkg::NUM_CH],
  output logic [SB-1:0] q_out [irpx_pkg::NUM_CH]
);
  import irpx_pkg::*;

  logic [SB-1:0] slot [NUM_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) slot[c] <= '0;
    end else if (shift) begin
      for (int c = 0; c < NUM_CH; c++) slot[c] <= d_in[c];
    end
  end

  assign q_out = slot;

endmodule

// ===== src/irpx_chain.sv =====
// Row of window cells with per-channel running sums and averages.
// Depends on irpx_pkg and irpx_cell.
module irpx_chain #(
  parameter int WINDOW = 8,
  parameter int SB     = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          lit_en,
  input  logic [SB-1:0] lit     [irpx_pkg::NUM_CH],
  input  logic [SB-1:0] ambient [irpx_pkg::NUM_CH],
  output logic [SB-1:0] avg     [irpx_pkg::NUM_CH]
);
  import irpx_pkg::*;

  localparam int SW = SB + $clog2(WINDOW) + 1;
  localparam int WB = $clog2(WINDOW);
  localparam int RK = SW + WB;
  localparam int PW = SW + RK + 1;
  localparam logic [RK:0] RECIP =
    (RK+1)'(((64'd1 << RK) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic [SB-1:0] diff  [NUM_CH];
  logic [SB-1:0] tap   [WINDOW+1][NUM_CH];
  logic [SW-1:0] sum   [NUM_CH];
  logic [SW-1:0] sum_next [NUM_CH];
  logic [PW-1:0] prod  [NUM_CH];

  // divide by WINDOW through a rounded-up reciprocal
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      diff[c] = (lit[c] > ambient[c]) ? lit[c] - ambient[c] : '0;
      sum_next[c] = sum[c] - SW'(tap[WINDOW][c]) + SW'(diff[c]);
      prod[c] = PW'(sum[c]) * PW'(RECIP);
      avg[c] = prod[c][RK +: SB];
    end
  end

  assign tap[0] = diff;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    irpx_cell #(.SB(SB)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (lit_en),
      .d_in  (tap[i]),
      .q_out (tap[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) sum[c] <= '0;
    end else if (lit_en) begin
      sum <= sum_next;
    end
  end

endmodule

// ===== verif/tb_ir_proximity_ambient_cancel_average.sv =====
// Self-checking testbench for ir_proximity_ambient_cancel_average: directed table, then
// phase-aligned random beats, checked against an in-bench sequencer predictor.
// Depends on irpx_pkg and the block's RTL.
module tb_ir_proximity_ambient_cancel_average;
  timeunit 1ns;
  timeprecision 1ps;

  import irpx_pkg::*;

  localparam int WIN          = 8;
  localparam int RANDOM_BEATS = 800;
  localparam int HOLD_FROM    = 400;
  localparam int HOLD_LEN     = 250;

  typedef struct packed {
    logic        start_conv;
    logic        emitter;
    phase_t      phase;
    logic [11:0] avg_fr;
    logic [11:0] avg_fl;
    logic [11:0] avg_bk;
  } reading_t;

  typedef struct packed {
    req_t        req;
    logic [11:0] fr;
    logic [11:0] fl;
    logic [11:0] bk;
    logic        typed;
    reading_t    want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        req_type = REQ_TICK;
  logic [11:0] sample_front_right = '0;
  logic [11:0] sample_front_left = '0;
  logic [11:0] sample_back = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        start_conversion;
  logic        emitter_on;
  logic [1:0]  phase_now;
  logic [11:0] avg_front_right;
  logic [11:0] avg_front_left;
  logic [11:0] avg_back;

  phase_t      pred_phase;
  logic        pred_emitter;
  logic [11:0] ambient_store [NUM_CH];
  logic [11:0] diff_win [WIN][NUM_CH];
  int unsigned win_ptr;
  logic [14:0] win_sum [NUM_CH];

  reading_t    expected_readings [$];
  int          errors = 0;
  int          results_seen = 0;
  int          beats_sent = 0;
  int          lit_count = 0;
  int unsigned burst_left = 0;

  ir_proximity_ambient_cancel_average u_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .req_type           (req_type),
    .sample_front_right (sample_front_right),
    .sample_front_left  (sample_front_left),
    .sample_back        (sample_back),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .start_conversion   (start_conversion),
    .emitter_on         (emitter_on),
    .phase_now          (phase_now),
    .avg_front_right    (avg_front_right),
    .avg_front_left     (avg_front_left),
    .avg_back           (avg_back)
  );

  always #5 clk = ~clk;

  function automatic reading_t step_sequencer(input req_t r, input logic [11:0] fr, fl, bk);
    logic [11:0] lit [NUM_CH];
    logic [11:0] avg [NUM_CH];
    logic [11:0] d;
    logic [14:0] q;
    reading_t    res;
    lit[0] = fr;
    lit[1] = fl;
    lit[2] = bk;
    if (r == REQ_CONV && pred_phase == PH_WAIT_AMB) begin
      for (int c = 0; c < NUM_CH; c++) ambient_store[c] = lit[c];
    end else if (r == REQ_CONV && pred_phase == PH_WAIT_LIT) begin
      for (int c = 0; c < NUM_CH; c++) begin
        d = (lit[c] > ambient_store[c]) ? lit[c] - ambient_store[c] : 12'd0;
        win_sum[c] = win_sum[c] - 15'(diff_win[win_ptr][c]) + 15'(d);
        diff_win[win_ptr][c] = d;
      end
      win_ptr = (win_ptr + 1) % WIN;
      lit_count++;
    end
    res.start_conv = (pred_phase == PH_START_AMB) || (pred_phase == PH_START_LIT);
    case (pred_phase)
      PH_WAIT_AMB: pred_emitter = 1'b1;
      PH_WAIT_LIT: pred_emitter = 1'b0;
      default: ;
    endcase
    pred_phase = phase_t'(pred_phase + 2'd1);
    for (int c = 0; c < NUM_CH; c++) begin
      q = 15'(win_sum[c] / WIN);
      avg[c] = (q > 15'd4095) ? 12'd4095 : q[11:0];
    end
    res.emitter = pred_emitter;
    res.phase   = pred_phase;
    res.avg_fr  = avg[0];
    res.avg_fl  = avg[1];
    res.avg_bk  = avg[2];
    return res;
  endfunction

  function automatic stim_row_t make_row(input req_t r, input logic [11:0] fr, fl, bk,
                                         input logic typed = 1'b0,
                                         input reading_t want = '0);
    stim_row_t row;
    row.req   = r;
    row.fr    = fr;
    row.fl    = fl;
    row.bk    = bk;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic reading_t fixed_reading(input logic s, e, input phase_t p,
                                             input logic [11:0] a);
    reading_t res;
    res.start_conv = s;
    res.emitter    = e;
    res.phase      = p;
    res.avg_fr     = a;
    res.avg_fl     = a;
    res.avg_bk     = a;
    return res;
  endfunction

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return 12'd0;
      1:       return 12'hFFF;
      2:       return 12'($urandom_range(0, 63));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic send_beat(input stim_row_t row);
    int unsigned gap;
    reading_t    pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid           <= 1'b1;
    req_type           <= row.req;
    sample_front_right <= row.fr;
    sample_front_left  <= row.fl;
    sample_back        <= row.bk;
    do @(posedge clk); while (!in_ready);
    pred = step_sequencer(row.req, row.fr, row.fl, row.bk);
    expected_readings.push_back(row.typed ? row.want : pred);
    beats_sent++;
  endtask

  task automatic check_field(input string name, input logic [11:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got phase %0d", $time,
                 phase_now);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        check_field("start_conversion", 12'(want.start_conv), 12'(start_conversion));
        check_field("emitter_on", 12'(want.emitter), 12'(emitter_on));
        check_field("phase_now", 12'(want.phase), 12'(phase_now));
        check_field("avg_front_right", want.avg_fr, avg_front_right);
        check_field("avg_front_left", want.avg_fl, avg_front_left);
        check_field("avg_back", want.avg_bk, avg_back);
        results_seen++;
      end
    end
  end

  initial begin
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= HOLD_FROM && cyc < HOLD_FROM + HOLD_LEN) begin
        out_ready <= 1'b0;
      end else begin
        case ((cyc / 64) % 4)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          2:       out_ready <= (cyc % 3 == 0);
          default: out_ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin
    stim_row_t dir_rows [$];
    req_t      r;
    pred_phase   = PH_START_AMB;
    pred_emitter = 1'b0;
    win_ptr      = 0;
    for (int c = 0; c < NUM_CH; c++) begin
      ambient_store[c] = '0;
      win_sum[c]       = '0;
      for (int w = 0; w < WIN; w++) diff_win[w][c] = '0;
    end

    dir_rows.push_back(make_row(REQ_TICK, 12'd0, 12'd0, 12'd0, 1'b1,
                                fixed_reading(1'b1, 1'b0, PH_WAIT_AMB, 12'd0)));
    dir_rows.push_back(make_row(REQ_CONV, 12'd0, 12'd0, 12'd0, 1'b1,
                                fixed_reading(1'b0, 1'b1, PH_START_LIT, 12'd0)));
    dir_rows.push_back(make_row(REQ_TICK, 12'd0, 12'd0, 12'd0, 1'b1,
                                fixed_reading(1'b1, 1'b1, PH_WAIT_LIT, 12'd0)));
    dir_rows.push_back(make_row(REQ_CONV, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1,
                                fixed_reading(1'b0, 1'b0, PH_START_AMB, 12'd511)));
    dir_rows.push_back(make_row(REQ_CONV, 12'hFFF, 12'hFFF, 12'hFFF));
    dir_rows.push_back(make_row(REQ_TICK, 12'hFFF, 12'hFFF, 12'hFFF));
    dir_rows.push_back(make_row(REQ_CONV, 12'h123, 12'h456, 12'h789));
    dir_rows.push_back(make_row(REQ_TICK, 12'h800, 12'h800, 12'h800));
    dir_rows.push_back(make_row(REQ_TICK, 12'd0, 12'd0, 12'd0));
    dir_rows.push_back(make_row(REQ_CONV, 12'hFFF, 12'hFFF, 12'hFFF));
    dir_rows.push_back(make_row(REQ_TICK, 12'd0, 12'd0, 12'd0));
    dir_rows.push_back(make_row(REQ_CONV, 12'h000, 12'h800, 12'hFFE));
    dir_rows.push_back(make_row(REQ_TICK, 12'd0, 12'd0, 12'd0));
    dir_rows.push_back(make_row(REQ_CONV, 12'h555, 12'hAAA, 12'h000));
    dir_rows.push_back(make_row(REQ_TICK, 12'd0, 12'd0, 12'd0));
    dir_rows.push_back(make_row(REQ_CONV, 12'hAAA, 12'h555, 12'hFFF));
    dir_rows.push_back(make_row(REQ_TICK, 12'd0, 12'd0, 12'd0));
    dir_rows.push_back(make_row(REQ_CONV, 12'h001, 12'h000, 12'hFFF));
    dir_rows.push_back(make_row(REQ_TICK, 12'd0, 12'd0, 12'd0));
    dir_rows.push_back(make_row(REQ_CONV, 12'h000, 12'hFFF, 12'hFFF));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_beat(dir_rows[i]);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if ($urandom_range(0, 9) != 0) r = (beats_sent % 2 == 1) ? REQ_CONV : REQ_TICK;
      else r = req_t'($urandom_range(0, 1));
      send_beat(make_row(r, pick_sample(), pick_sample(), pick_sample()));
    end
    in_valid <= 1'b0;

    while (expected_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d beats (%0d lit conversions into the window), checked %0d results,",
             beats_sent, lit_count, results_seen);
    $display("with sender gaps, receiver stalls and one %0d-cycle receiver hold-off.",
             HOLD_LEN);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", expected_readings.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
